// ----- src/bbi_pkg.sv -----
package bbi_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 31;

	typedef enum logic [1:0] {
		CMD_STEP = 2'd0,
		CMD_REGISTER = 2'd1,
		CMD_IMPULSE = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_EMPTY = 2'd1,
		ST_IN_USE = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRAVITY = 3'd0,
		REG_DAMPING = 3'd1,
		REG_BOUNCE = 3'd2,
		REG_FRICTION = 3'd3,
		REG_SLEEP_SPEED = 3'd4,
		REG_SLEEP_DELAY = 3'd5,
		REG_RADIUS = 3'd6,
		REG_MOVE_EPS = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] command;
		logic [3:0] slot;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic [12:0] step_time;
		logic signed [31:0] ground_z;
		logic ground_hit;
	} in_item_t;

	typedef struct packed {
		logic [3:0] out_slot;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic moved;
		logic asleep;
		logic [1:0] status;
	} out_item_t;

	typedef struct packed {
		logic signed [23:0] gravity;
		logic [15:0] linear_damping;
		logic [15:0] bounce;
		logic [15:0] friction;
		logic [30:0] sleep_speed;
		logic [23:0] sleep_delay;
		logic [30:0] body_radius;
		logic [30:0] move_epsilon;
	} cfg_t;

	// datapath micro-operations issued by the controller
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_DAMP_F,
		OP_DAMP0,
		OP_DAMP1,
		OP_DAMP2,
		OP_GRAV,
		OP_MOVE0,
		OP_MOVE1,
		OP_MOVE2,
		OP_CONTACT,
		OP_BOUNCE,
		OP_FRIC0,
		OP_FRIC1,
		OP_SQ0,
		OP_SQ1,
		OP_SQ2,
		OP_REST,
		OP_D0,
		OP_D1,
		OP_D2,
		OP_MOVED,
		OP_REG_SQ0,
		OP_REG_SQ1,
		OP_REG_SQ2,
		OP_REG_WRITE,
		OP_IMPULSE,
		OP_WRITE_BACK
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD, S_DF, S_D0, S_D1, S_D2, S_GR, S_M0, S_M1, S_M2, S_CT,
		S_BO, S_F0, S_F1, S_Q0, S_Q1, S_Q2, S_RT, S_X0, S_X1, S_X2, S_MV,
		S_R0, S_R1, S_R2, S_RW, S_IMP, S_WB, S_OUT
	} state_t;

	typedef struct packed {
		logic valid;
		logic sleeping;
	} dp_status_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'sd2147483647) return 32'sh7FFFFFFF;
		if (x < -66'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

endpackage

// ----- src/bouncing_body_integrator_core.sv -----
// channel | signals                         | handshake
// in      | start, busy, in_item            | taken when start & !busy
// out     | done, out_item                  | one-cycle strobe, no back-pressure
// cfg     | cfg_we, cfg_index, cfg_data     | written when cfg_we
// The sequencer issues at most one datapath micro-op per state; a step walks damping,
// gravity, motion, ground contact, bounce, friction, rest and movement checks.
// Reset clears the sequencer and the slot valid bits and loads the config registers with defaults.
// busy goes high once an item is accepted and stays high through the done cycle; results cannot stall.
module bouncing_body_integrator_core #(
	parameter int unsigned BODY_SLOTS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input bbi_pkg::in_item_t in_item,
	output logic done,
	output bbi_pkg::out_item_t out_item,
	input logic cfg_we,
	input logic [bbi_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [bbi_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bbi_pkg::*;

	cfg_t cfg_q;
	op_t op;
	dp_status_t st;
	logic [1:0] cmd_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gravity <= -24'sd160563;
			cfg_q.linear_damping <= 16'd26;
			cfg_q.bounce <= 16'd19661;
			cfg_q.friction <= 16'd52429;
			cfg_q.sleep_speed <= 31'd1280;
			cfg_q.sleep_delay <= 24'd32768;
			cfg_q.body_radius <= 31'd1280;
			cfg_q.move_epsilon <= 31'd13;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
			REG_GRAVITY: cfg_q.gravity <= cfg_data[23:0];
			REG_DAMPING: cfg_q.linear_damping <= cfg_data[15:0];
			REG_BOUNCE: cfg_q.bounce <= cfg_data[15:0];
			REG_FRICTION: cfg_q.friction <= cfg_data[15:0];
			REG_SLEEP_SPEED: cfg_q.sleep_speed <= cfg_data;
			REG_SLEEP_DELAY: cfg_q.sleep_delay <= cfg_data[23:0];
			REG_RADIUS: cfg_q.body_radius <= cfg_data;
			REG_MOVE_EPS: cfg_q.move_epsilon <= cfg_data;
			default: ;
			endcase
		end
	end

	// command held for the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cmd_q <= CMD_STEP;
		else if (start && !busy) cmd_q <= in_item.command;
	end

	bbi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .command(cmd_q),
		.st(st), .busy(busy), .done(done), .op(op)
	);

	bbi_datapath #(.BODY_SLOTS(BODY_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .item(in_item), .op(op),
		.st(st), .result(out_item)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done without busy");
	a_no_double_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done twice");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted item not busy");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_item.status == ST_DONE || out_item.status == ST_EMPTY
		|| out_item.status == ST_IN_USE)) else $error("bad status");

endmodule

// ----- src/bbi_datapath.sv -----
module bbi_datapath #(
	parameter int unsigned BODY_SLOTS = 16
) (
	input logic clk,
	input logic arst_n,
	input bbi_pkg::cfg_t cfg,
	input bbi_pkg::in_item_t item,
	input bbi_pkg::op_t op,
	output bbi_pkg::dp_status_t st,
	output bbi_pkg::out_item_t result
);
	import bbi_pkg::*;

	localparam int unsigned IW = (BODY_SLOTS > 1) ? $clog2(BODY_SLOTS) : 1;

	// body table
	logic [BODY_SLOTS-1:0] valid_q;
	logic signed [31:0] pos_q [BODY_SLOTS][3];
	logic signed [31:0] vel_q [BODY_SLOTS][3];
	logic sleep_q [BODY_SLOTS];
	logic [23:0] rest_q [BODY_SLOTS];

	// working registers
	in_item_t it_q;
	logic signed [31:0] p_q [3];
	logic signed [31:0] np_q [3];
	logic signed [31:0] v_q [3];
	logic sl_q;
	logic [23:0] rt_q;
	logic [24:0] f_q;
	logic ground_q, moved_q, have_q;
	logic [1:0] status_q;
	logic [65:0] acc_q;

	logic in_range;
	logic [IW-1:0] idx;
	assign in_range = ({28'd0, item.slot} < 32'(BODY_SLOTS));
	assign idx = IW'(it_q.slot);
	assign st.valid = have_q;
	assign st.sleeping = sl_q;

	// rounded signed scale: round(x*m/2^sh), ties away from zero
	function automatic logic signed [65:0] scl(input logic signed [32:0] x,
		input logic [24:0] m, input int unsigned sh);
		logic [32:0] mag;
		logic [65:0] r;
		mag = x[32] ? 33'(-x) : 33'(x);
		r = (66'(mag) * 66'(m) + (66'd1 << (sh - 1))) >> sh;
		return x[32] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic [65:0] sqm(input logic signed [32:0] x);
		logic [32:0] mag;
		mag = x[32] ? 33'(-x) : 33'(x);
		return 66'(mag) * 66'(mag);
	endfunction

	logic [28:0] prod;
	logic [24:0] t_sum;
	logic [23:0] t_new;
	logic signed [32:0] gsum;
	assign prod = 29'(cfg.linear_damping) * 29'(it_q.step_time);
	assign t_sum = 25'(rt_q) + 25'(it_q.step_time);
	assign t_new = t_sum[24] ? 24'hFFFFFF : t_sum[23:0];
	assign gsum = 33'(signed'(it_q.ground_z)) + 33'(signed'({1'b0, cfg.body_radius}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (op == OP_REG_WRITE && status_q == ST_DONE)
				valid_q[idx] <= 1'b1;
			if (op == OP_WRITE_BACK && have_q && it_q.command == CMD_REMOVE)
				valid_q[idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (op)
		OP_LOAD: begin
			it_q <= item;
			have_q <= in_range && valid_q[IW'(item.slot)];
			p_q <= pos_q[IW'(item.slot)];
			np_q <= pos_q[IW'(item.slot)];
			v_q <= vel_q[IW'(item.slot)];
			sl_q <= sleep_q[IW'(item.slot)];
			rt_q <= rest_q[IW'(item.slot)];
			moved_q <= 1'b0;
			ground_q <= 1'b0;
			acc_q <= '0;
			if (item.command == CMD_REGISTER)
				status_q <= (!in_range || valid_q[IW'(item.slot)]) ? ST_IN_USE : ST_DONE;
			else
				status_q <= (in_range && valid_q[IW'(item.slot)]) ? ST_DONE : ST_EMPTY;
		end
		OP_DAMP_F: f_q <= (prod >= 29'h1000000) ? 25'd0 : 25'(29'h1000000 - prod);
		OP_DAMP0: v_q[0] <= sat32(scl(33'(v_q[0]), f_q, 24));
		OP_DAMP1: v_q[1] <= sat32(scl(33'(v_q[1]), f_q, 24));
		OP_DAMP2: v_q[2] <= sat32(scl(33'(v_q[2]), f_q, 24));
		OP_GRAV: v_q[2] <= sat32(66'(v_q[2]) + scl(33'(cfg.gravity), 25'(it_q.step_time), 16));
		OP_MOVE0: np_q[0] <= sat32(66'(p_q[0]) + scl(33'(v_q[0]), 25'(it_q.step_time), 16));
		OP_MOVE1: np_q[1] <= sat32(66'(p_q[1]) + scl(33'(v_q[1]), 25'(it_q.step_time), 16));
		OP_MOVE2: np_q[2] <= sat32(66'(p_q[2]) + scl(33'(v_q[2]), 25'(it_q.step_time), 16));
		OP_CONTACT: if (it_q.ground_hit && 33'(np_q[2]) < gsum) begin
			ground_q <= 1'b1;
			np_q[2] <= sat32(66'(gsum));
		end
		OP_BOUNCE: if (ground_q && v_q[2][31])
			v_q[2] <= sat32(-scl(33'(v_q[2]), 25'(cfg.bounce), 16));
		OP_FRIC0: if (ground_q) v_q[0] <= sat32(scl(33'(v_q[0]), 25'(cfg.friction), 16));
		OP_FRIC1: if (ground_q) v_q[1] <= sat32(scl(33'(v_q[1]), 25'(cfg.friction), 16));
		OP_SQ0, OP_REG_SQ0: acc_q <= sqm(33'(op == OP_SQ0 ? v_q[0] : it_q.vel_x));
		OP_SQ1, OP_REG_SQ1: acc_q <= acc_q + sqm(33'(op == OP_SQ1 ? v_q[1] : it_q.vel_y));
		OP_SQ2, OP_REG_SQ2: acc_q <= acc_q + sqm(33'(op == OP_SQ2 ? v_q[2] : it_q.vel_z));
		OP_REST: begin
			if (ground_q && acc_q < 66'(cfg.sleep_speed) * 66'(cfg.sleep_speed)) begin
				rt_q <= t_new;
				if (t_new >= cfg.sleep_delay) begin
					v_q[0] <= '0; v_q[1] <= '0; v_q[2] <= '0;
					sl_q <= 1'b1;
				end
			end else begin
				rt_q <= '0;
			end
			acc_q <= '0;
		end
		OP_D0: acc_q <= sqm(33'(np_q[0]) - 33'(p_q[0]));
		OP_D1: acc_q <= acc_q + sqm(33'(np_q[1]) - 33'(p_q[1]));
		OP_D2: acc_q <= acc_q + sqm(33'(np_q[2]) - 33'(p_q[2]));
		OP_MOVED: moved_q <= acc_q > 66'(cfg.move_epsilon) * 66'(cfg.move_epsilon);
		OP_REG_WRITE: if (status_q == ST_DONE) begin
			np_q[0] <= it_q.pos_x; np_q[1] <= it_q.pos_y; np_q[2] <= it_q.pos_z;
			v_q[0] <= it_q.vel_x; v_q[1] <= it_q.vel_y; v_q[2] <= it_q.vel_z;
			sl_q <= acc_q < 66'(cfg.sleep_speed) * 66'(cfg.sleep_speed);
			rt_q <= '0;
			have_q <= 1'b1;
			pos_q[idx] <= '{it_q.pos_x, it_q.pos_y, it_q.pos_z};
			vel_q[idx] <= '{it_q.vel_x, it_q.vel_y, it_q.vel_z};
			sleep_q[idx] <= acc_q < 66'(cfg.sleep_speed) * 66'(cfg.sleep_speed);
			rest_q[idx] <= '0;
		end
		OP_IMPULSE: begin
			v_q[0] <= sat32(66'(v_q[0]) + 66'(it_q.vel_x));
			v_q[1] <= sat32(66'(v_q[1]) + 66'(it_q.vel_y));
			v_q[2] <= sat32(66'(v_q[2]) + 66'(it_q.vel_z));
			sl_q <= 1'b0;
			rt_q <= '0;
		end
		OP_WRITE_BACK: if (have_q && it_q.command != CMD_REMOVE) begin
			pos_q[idx] <= np_q;
			vel_q[idx] <= v_q;
			sleep_q[idx] <= sl_q;
			rest_q[idx] <= rt_q;
		end
		default: ;
		endcase
	end

	// result assembly
	always_comb begin
		result.out_slot = it_q.slot;
		result.out_x = have_q ? np_q[0] : '0;
		result.out_y = have_q ? np_q[1] : '0;
		result.out_z = have_q ? np_q[2] : '0;
		result.asleep = have_q ? sl_q : 1'b0;
		result.moved = moved_q;
		result.status = status_q;
	end

endmodule

// ----- src/bbi_ctrl.sv -----
module bbi_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [1:0] command,
	input bbi_pkg::dp_status_t st,
	output logic busy,
	output logic done,
	output bbi_pkg::op_t op
);
	import bbi_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// sequencer: at most one micro-op per state
	always_comb begin
		state_d = state_q;
		op = OP_NONE;
		busy = (state_q != S_IDLE);
		done = 1'b0;
		case (state_q)
		S_IDLE: if (start) begin
			op = OP_LOAD;
			state_d = S_LOAD;
		end
		S_LOAD: begin
			if (command == CMD_REGISTER) state_d = S_R0;
			else if (!st.valid) state_d = S_OUT;
			else if (command == CMD_STEP) state_d = st.sleeping ? S_OUT : S_DF;
			else if (command == CMD_IMPULSE) state_d = S_IMP;
			else state_d = S_WB;
		end
		S_DF: begin op = OP_DAMP_F; state_d = S_D0; end
		S_D0: begin op = OP_DAMP0; state_d = S_D1; end
		S_D1: begin op = OP_DAMP1; state_d = S_D2; end
		S_D2: begin op = OP_DAMP2; state_d = S_GR; end
		S_GR: begin op = OP_GRAV; state_d = S_M0; end
		S_M0: begin op = OP_MOVE0; state_d = S_M1; end
		S_M1: begin op = OP_MOVE1; state_d = S_M2; end
		S_M2: begin op = OP_MOVE2; state_d = S_CT; end
		S_CT: begin op = OP_CONTACT; state_d = S_BO; end
		S_BO: begin op = OP_BOUNCE; state_d = S_F0; end
		S_F0: begin op = OP_FRIC0; state_d = S_F1; end
		S_F1: begin op = OP_FRIC1; state_d = S_Q0; end
		S_Q0: begin op = OP_SQ0; state_d = S_Q1; end
		S_Q1: begin op = OP_SQ1; state_d = S_Q2; end
		S_Q2: begin op = OP_SQ2; state_d = S_RT; end
		S_RT: begin op = OP_REST; state_d = S_X0; end
		S_X0: begin op = OP_D0; state_d = S_X1; end
		S_X1: begin op = OP_D1; state_d = S_X2; end
		S_X2: begin op = OP_D2; state_d = S_MV; end
		S_MV: begin op = OP_MOVED; state_d = S_WB; end
		S_R0: begin op = OP_REG_SQ0; state_d = S_R1; end
		S_R1: begin op = OP_REG_SQ1; state_d = S_R2; end
		S_R2: begin op = OP_REG_SQ2; state_d = S_RW; end
		S_RW: begin op = OP_REG_WRITE; state_d = S_OUT; end
		S_IMP: begin op = OP_IMPULSE; state_d = S_WB; end
		S_WB: begin op = OP_WRITE_BACK; state_d = S_OUT; end
		S_OUT: begin done = 1'b1; state_d = S_IDLE; end
		default: state_d = S_IDLE;
		endcase
	end

endmodule
